// ----- sv/pma_pkg.sv -----
// Shared constants, codes and controller-to-datapath types of the paged memory allocator.
package pma_pkg;

    localparam int PAGE_BYTES     = 256;
    localparam int NUM_PAGES      = 64;
    localparam int TABLE_PTR_BASE = 64;
    localparam int RAM_BYTES      = PAGE_BYTES * NUM_PAGES;

    localparam int OFF_W  = $clog2(PAGE_BYTES);
    localparam int PAGE_W = $clog2(NUM_PAGES);
    localparam int ADDR_W = OFF_W + PAGE_W;
    localparam int CNT_W  = OFF_W + 1;
    localparam int SCAN_W = PAGE_W + 1;
    localparam int BYTE_W = 8;
    localparam int VA_W   = 16;
    localparam int PCNT_W = 7;
    localparam int PID_W  = 6;

    typedef enum logic [1:0] {
        REQ_NEW   = 2'd0,
        REQ_KILL  = 2'd1,
        REQ_STORE = 2'd2,
        REQ_LOAD  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_TABLE = 2'd1,
        ST_NO_DATA  = 2'd2,
        ST_FAULT    = 2'd3
    } stat_t;

    typedef enum logic [1:0] {
        MEM_NONE,
        MEM_RD,
        MEM_WR
    } mem_op_t;

    typedef enum logic [3:0] {
        A_PTR,
        A_SCAN,
        A_TBL_ENT,
        A_ENTRY_VP,
        A_PHYS,
        A_CLEAR_PG,
        A_MAP_PG,
        A_MAP_TBL,
        A_SWEEP
    } asel_t;

    typedef enum logic [2:0] {
        W_ZERO,
        W_ONE,
        W_SCAN,
        W_STORE,
        W_SWEEP
    } wsel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        mem_op_t mem_op;
        asel_t   asel;
        wsel_t   wsel;
        logic    cap_req;
        logic    ld_tbl_mem;
        logic    ld_tbl_scan;
        logic    ld_pg;
        logic    ld_pa;
        logic    scan_init;
        logic    scan_inc;
        logic    idx_clr;
        logic    idx_inc;
        logic    clr_clr;
        logic    clr_inc;
        logic    sweep_inc;
        logic    ld_res;
        stat_t   res_status;
        logic    res_pa;
        logic    res_ld;
    } cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        req_t req;
        logic vp_ok;
        logic rd_zero;
        logic rd_lt;
        logic rd_page_ok;
        logic scan_end;
        logic idx_done_new;
        logic idx_done_kill;
        logic clr_last;
        logic sweep_last;
    } stat_bus_t;

endpackage

// ----- sv/pma_dp.sv -----
// Datapath of the paged memory allocator: byte memory, address muxing and work registers.
module pma_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pma_pkg::cmd_t                  cmd,
    input  logic [1:0]                     req_type,
    input  logic [pma_pkg::PID_W-1:0]      proc_id,
    input  logic [pma_pkg::PCNT_W-1:0]     data_pages,
    input  logic [pma_pkg::VA_W-1:0]       vaddr,
    input  logic [pma_pkg::BYTE_W-1:0]     store_data,
    output pma_pkg::stat_bus_t             sts,
    output logic [1:0]                     status,
    output logic [pma_pkg::ADDR_W-1:0]     paddr,
    output logic [pma_pkg::BYTE_W-1:0]     load_data
);

    logic [pma_pkg::BYTE_W-1:0] ram [pma_pkg::RAM_BYTES];
    logic [pma_pkg::BYTE_W-1:0] rdata_reg;

    logic [1:0]                 req_reg;
    logic [pma_pkg::PID_W-1:0]  pid_reg;
    logic [pma_pkg::CNT_W-1:0]  cnt_reg;
    logic [pma_pkg::VA_W-1:0]   va_reg;
    logic [pma_pkg::BYTE_W-1:0] sd_reg;

    logic [pma_pkg::SCAN_W-1:0] scan_reg;
    logic [pma_pkg::PAGE_W-1:0] tbl_reg;
    logic [pma_pkg::PAGE_W-1:0] pg_reg;
    logic [pma_pkg::CNT_W-1:0]  idx_reg;
    logic [pma_pkg::OFF_W-1:0]  clr_reg;
    logic [pma_pkg::ADDR_W-1:0] sweep_reg;
    logic [pma_pkg::ADDR_W-1:0] pa_reg;

    logic [1:0]                 status_reg;
    logic [pma_pkg::ADDR_W-1:0] phys_reg;
    logic [pma_pkg::BYTE_W-1:0] ld_reg;

    logic [pma_pkg::ADDR_W-1:0] addr;
    logic [pma_pkg::BYTE_W-1:0] wdata;

    // Address selection.
    always_comb
    begin
        case (cmd.asel)
            pma_pkg::A_PTR:      addr = pma_pkg::ADDR_W'(pma_pkg::TABLE_PTR_BASE + int'(pid_reg));
            pma_pkg::A_SCAN:     addr = pma_pkg::ADDR_W'(scan_reg);
            pma_pkg::A_TBL_ENT:  addr = {tbl_reg, idx_reg[pma_pkg::OFF_W-1:0]};
            pma_pkg::A_ENTRY_VP: addr = {tbl_reg, pma_pkg::OFF_W'(va_reg >> pma_pkg::OFF_W)};
            pma_pkg::A_PHYS:     addr = pa_reg;
            pma_pkg::A_CLEAR_PG: addr = {pg_reg, clr_reg};
            pma_pkg::A_MAP_PG:   addr = pma_pkg::ADDR_W'(pg_reg);
            pma_pkg::A_MAP_TBL:  addr = pma_pkg::ADDR_W'(tbl_reg);
            pma_pkg::A_SWEEP:    addr = sweep_reg;
            default:             addr = '0;
        endcase
    end

    // Write data selection; the sweep puts 1 in the map byte of page 0.
    always_comb
    begin
        case (cmd.wsel)
            pma_pkg::W_ZERO:  wdata = '0;
            pma_pkg::W_ONE:   wdata = pma_pkg::BYTE_W'(1);
            pma_pkg::W_SCAN:  wdata = pma_pkg::BYTE_W'(scan_reg);
            pma_pkg::W_STORE: wdata = sd_reg;
            pma_pkg::W_SWEEP: wdata = (sweep_reg == '0) ? pma_pkg::BYTE_W'(1) : '0;
            default:          wdata = '0;
        endcase
    end

    // Single-port byte memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (cmd.mem_op == pma_pkg::MEM_WR)
        begin
            ram[addr] <= wdata;
        end
        if (cmd.mem_op == pma_pkg::MEM_RD)
        begin
            rdata_reg <= ram[addr];
        end
    end

    // Request capture and payload work registers.
    always_ff @(posedge clk)
    begin
        if (cmd.cap_req)
        begin
            req_reg <= req_type;
            pid_reg <= proc_id;
            va_reg  <= vaddr;
            sd_reg  <= store_data;
            if (32'(data_pages) > pma_pkg::PAGE_BYTES)
            begin
                cnt_reg <= pma_pkg::CNT_W'(pma_pkg::PAGE_BYTES);
            end
            else
            begin
                cnt_reg <= pma_pkg::CNT_W'(data_pages);
            end
        end
        if (cmd.ld_tbl_mem)
        begin
            tbl_reg <= rdata_reg[pma_pkg::PAGE_W-1:0];
        end
        else if (cmd.ld_tbl_scan)
        begin
            tbl_reg <= scan_reg[pma_pkg::PAGE_W-1:0];
        end
        if (cmd.ld_pg)
        begin
            pg_reg <= rdata_reg[pma_pkg::PAGE_W-1:0];
        end
        if (cmd.ld_pa)
        begin
            pa_reg <= {rdata_reg[pma_pkg::PAGE_W-1:0], va_reg[pma_pkg::OFF_W-1:0]};
        end
        if (cmd.scan_init)
        begin
            scan_reg <= pma_pkg::SCAN_W'(1);
        end
        else if (cmd.scan_inc)
        begin
            scan_reg <= scan_reg + 1'b1;
        end
        if (cmd.idx_clr)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.clr_clr)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr_inc)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
        if (cmd.ld_res)
        begin
            status_reg <= cmd.res_status;
            phys_reg   <= cmd.res_pa ? pa_reg : '0;
            ld_reg     <= cmd.res_ld ? rdata_reg : '0;
        end
    end

    // Power-up sweep address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
        end
        else if (cmd.sweep_inc)
        begin
            sweep_reg <= sweep_reg + 1'b1;
        end
    end

    // Status toward the controller.
    always_comb
    begin
        sts.req           = pma_pkg::req_t'(req_reg);
        sts.vp_ok         = 32'(va_reg >> pma_pkg::OFF_W) < pma_pkg::PAGE_BYTES;
        sts.rd_zero       = (rdata_reg == '0);
        sts.rd_lt         = 32'(rdata_reg) < pma_pkg::NUM_PAGES;
        sts.rd_page_ok    = (rdata_reg != '0) && (32'(rdata_reg) < pma_pkg::NUM_PAGES);
        sts.scan_end      = 32'(scan_reg) == pma_pkg::NUM_PAGES;
        sts.idx_done_new  = (idx_reg == cnt_reg);
        sts.idx_done_kill = 32'(idx_reg) == pma_pkg::PAGE_BYTES;
        sts.clr_last      = &clr_reg;
        sts.sweep_last    = &sweep_reg;
    end

    assign status    = status_reg;
    assign paddr     = phys_reg;
    assign load_data = ld_reg;

endmodule

// ----- sv/pma_ctrl.sv -----
// Controller state machine of the paged memory allocator.
module pma_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  pma_pkg::stat_bus_t sts,
    output pma_pkg::cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_PTR_RD,
        S_PTR_CHK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_PTR_WR,
        S_ENT_WR,
        S_DATA_CHK,
        S_KENT_RD,
        S_KENT_CHK,
        S_KCLR,
        S_KMAP,
        S_AENT_RD,
        S_AENT_CHK,
        S_STORE,
        S_LOAD_RD,
        S_LOAD_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   table_reg, table_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        table_next = table_reg;
        cmd        = '0;
        cmd.mem_op = pma_pkg::MEM_NONE;
        cmd.asel   = pma_pkg::A_PTR;
        cmd.wsel   = pma_pkg::W_ZERO;
        cmd.res_status = pma_pkg::ST_OK;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.mem_op    = pma_pkg::MEM_WR;
                cmd.asel      = pma_pkg::A_SWEEP;
                cmd.wsel      = pma_pkg::W_SWEEP;
                cmd.sweep_inc = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.cap_req   = 1'b1;
                    cmd.scan_init = 1'b1;
                    table_next    = 1'b1;
                    state_next    = S_PTR_RD;
                end
            end
            S_PTR_RD:
            begin
                if (sts.req == pma_pkg::REQ_NEW)
                begin
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    cmd.mem_op = pma_pkg::MEM_RD;
                    cmd.asel   = pma_pkg::A_PTR;
                    state_next = S_PTR_CHK;
                end
            end
            S_PTR_CHK:
            begin
                if (sts.req == pma_pkg::REQ_KILL)
                begin
                    if (sts.rd_page_ok)
                    begin
                        cmd.ld_tbl_mem = 1'b1;
                        cmd.idx_clr    = 1'b1;
                        state_next     = S_KENT_RD;
                    end
                    else
                    begin
                        cmd.ld_res = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (sts.rd_lt && sts.vp_ok)
                begin
                    cmd.ld_tbl_mem = 1'b1;
                    state_next     = S_AENT_RD;
                end
                else
                begin
                    cmd.ld_res     = 1'b1;
                    cmd.res_status = pma_pkg::ST_FAULT;
                    state_next     = S_IDLE;
                end
            end
            S_SCAN_RD:
            begin
                if (sts.scan_end)
                begin
                    cmd.ld_res     = 1'b1;
                    cmd.res_status = table_reg ? pma_pkg::ST_NO_TABLE : pma_pkg::ST_NO_DATA;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.mem_op = pma_pkg::MEM_RD;
                    cmd.asel   = pma_pkg::A_SCAN;
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (sts.rd_zero)
                begin
                    cmd.mem_op = pma_pkg::MEM_WR;
                    cmd.asel   = pma_pkg::A_SCAN;
                    cmd.wsel   = pma_pkg::W_ONE;
                    state_next = table_reg ? S_PTR_WR : S_ENT_WR;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_SCAN_RD;
                end
            end
            S_PTR_WR:
            begin
                cmd.mem_op      = pma_pkg::MEM_WR;
                cmd.asel        = pma_pkg::A_PTR;
                cmd.wsel        = pma_pkg::W_SCAN;
                cmd.ld_tbl_scan = 1'b1;
                cmd.idx_clr     = 1'b1;
                table_next      = 1'b0;
                state_next      = S_DATA_CHK;
            end
            S_ENT_WR:
            begin
                cmd.mem_op  = pma_pkg::MEM_WR;
                cmd.asel    = pma_pkg::A_TBL_ENT;
                cmd.wsel    = pma_pkg::W_SCAN;
                cmd.idx_inc = 1'b1;
                state_next  = S_DATA_CHK;
            end
            S_DATA_CHK:
            begin
                if (sts.idx_done_new)
                begin
                    cmd.ld_res = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    // Pages below the last grab are all in use, so the scan goes on from there.
                    cmd.scan_inc = 1'b1;
                    state_next   = S_SCAN_RD;
                end
            end
            S_KENT_RD:
            begin
                if (sts.idx_done_kill)
                begin
                    cmd.mem_op = pma_pkg::MEM_WR;
                    cmd.asel   = pma_pkg::A_MAP_TBL;
                    cmd.wsel   = pma_pkg::W_ZERO;
                    cmd.ld_res = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.mem_op = pma_pkg::MEM_RD;
                    cmd.asel   = pma_pkg::A_TBL_ENT;
                    state_next = S_KENT_CHK;
                end
            end
            S_KENT_CHK:
            begin
                cmd.idx_inc = 1'b1;
                if (sts.rd_page_ok)
                begin
                    cmd.ld_pg   = 1'b1;
                    cmd.clr_clr = 1'b1;
                    state_next  = S_KCLR;
                end
                else
                begin
                    state_next = S_KENT_RD;
                end
            end
            S_KCLR:
            begin
                cmd.mem_op  = pma_pkg::MEM_WR;
                cmd.asel    = pma_pkg::A_CLEAR_PG;
                cmd.wsel    = pma_pkg::W_ZERO;
                cmd.clr_inc = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_KMAP;
                end
            end
            S_KMAP:
            begin
                cmd.mem_op = pma_pkg::MEM_WR;
                cmd.asel   = pma_pkg::A_MAP_PG;
                cmd.wsel   = pma_pkg::W_ZERO;
                state_next = S_KENT_RD;
            end
            S_AENT_RD:
            begin
                cmd.mem_op = pma_pkg::MEM_RD;
                cmd.asel   = pma_pkg::A_ENTRY_VP;
                state_next = S_AENT_CHK;
            end
            S_AENT_CHK:
            begin
                if (sts.rd_page_ok)
                begin
                    cmd.ld_pa  = 1'b1;
                    state_next = (sts.req == pma_pkg::REQ_STORE) ? S_STORE : S_LOAD_RD;
                end
                else
                begin
                    cmd.ld_res     = 1'b1;
                    cmd.res_status = pma_pkg::ST_FAULT;
                    state_next     = S_IDLE;
                end
            end
            S_STORE:
            begin
                cmd.mem_op = pma_pkg::MEM_WR;
                cmd.asel   = pma_pkg::A_PHYS;
                cmd.wsel   = pma_pkg::W_STORE;
                cmd.ld_res = 1'b1;
                cmd.res_pa = 1'b1;
                state_next = S_IDLE;
            end
            S_LOAD_RD:
            begin
                cmd.mem_op = pma_pkg::MEM_RD;
                cmd.asel   = pma_pkg::A_PHYS;
                state_next = S_LOAD_DONE;
            end
            S_LOAD_DONE:
            begin
                cmd.ld_res = 1'b1;
                cmd.res_pa = 1'b1;
                cmd.res_ld = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // The output slot fills on a result and empties on a transfer.
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.ld_res)
        begin
            out_valid_next = 1'b1;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            table_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            table_reg     <= table_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A request is taken only when the output slot is free or emptying.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!out_valid_reg || out_ready))
        else $error("request accepted while a result is still waiting");

    // A new result never overwrites one that has not been transferred.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_res |-> !out_valid_reg)
        else $error("result loaded over a pending result");

    // After a request is taken the block stays busy until it has answered.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("second request accepted during work");

    // No request is taken during the power-up memory sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_ready)
        else $error("ready during memory sweep");

endmodule

// ----- sv/paged_memory_allocator_mmu.sv -----
// Top level of the paged memory allocator with page-table address translation.
//
// Requests enter on the in channel (in_valid/in_ready) with req_type, proc_id,
// data_pages, vaddr and store_data; each request gives exactly one result on the
// out channel (out_valid/out_ready) with status, paddr and load_data.
// Requests are handled one at a time by a state machine driving a single-port
// 16 KiB byte memory with registered read data.
// After reset the block sweeps the whole memory to zero with a 1 in map byte 0,
// and holds in_ready low until the sweep ends.
// A new process scans the map bytes for free pages, taking one for its table and
// one per data page; a kill walks every table entry and frees each data page it
// maps by clearing its bytes and its map byte, then frees the table page.
// The result waits in an output register; a new request is accepted once that
// register is empty or is being emptied, so a stalled receiver holds the block.
module paged_memory_allocator_mmu (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 req_type,
    input  logic [pma_pkg::PID_W-1:0]  proc_id,
    input  logic [pma_pkg::PCNT_W-1:0] data_pages,
    input  logic [pma_pkg::VA_W-1:0]   vaddr,
    input  logic [pma_pkg::BYTE_W-1:0] store_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 status,
    output logic [pma_pkg::ADDR_W-1:0] paddr,
    output logic [pma_pkg::BYTE_W-1:0] load_data
);

    pma_pkg::cmd_t      cmd;
    pma_pkg::stat_bus_t sts;

    // Sequencer.
    pma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Memory and work registers.
    pma_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .req_type   (req_type),
        .proc_id    (proc_id),
        .data_pages (data_pages),
        .vaddr      (vaddr),
        .store_data (store_data),
        .sts        (sts),
        .status     (status),
        .paddr      (paddr),
        .load_data  (load_data)
    );

endmodule
